// ----- sv/rihw_pkg.sv -----
package rihw_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 5;
  localparam int WORD_W      = 32;

  // Request codes carried on the input tuser.
  typedef enum logic [2:0] {
    ACT_LOOKUP   = 3'd0,
    ACT_CAPACITY = 3'd1,
    ACT_REMEMBER = 3'd2,
    ACT_EXPIRE   = 3'd3,
    ACT_DUMP     = 3'd4
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic restart;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
    logic out_free;
    logic more;
  } sts_t;

endpackage

// ----- sv/rihw_ctrl.sv -----
module rihw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  rihw_pkg::sts_t   sts,
  output rihw_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.scan_end) begin
          cmd.step = 1'b1;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          if (sts.more) begin
            cmd.restart = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/rihw_dp.sv -----
module rihw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [2:0]                    in_action,
  input  logic [rihw_pkg::WORD_W-1:0]   in_id,
  input  logic [rihw_pkg::WORD_W-1:0]   in_gen,
  input  logic [rihw_pkg::WORD_W-1:0]   in_tick,
  input  logic [rihw_pkg::CNT_W-1:0]    in_limit,
  input  rihw_pkg::cmd_t                cmd,
  output rihw_pkg::sts_t                sts,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [135:0]                  out_tdata,
  output logic                          out_tlast
);

  localparam int W  = rihw_pkg::WORD_W;
  localparam int CW = rihw_pkg::CNT_W;
  localparam int IW = rihw_pkg::IDX_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(rihw_pkg::TABLE_DEPTH);

  // Table storage, read at the scan index and, for a remember hit, at the hit index.
  logic [W-1:0] ids_r  [rihw_pkg::TABLE_DEPTH];
  logic [W-1:0] gens_r [rihw_pkg::TABLE_DEPTH];
  logic [W-1:0] ticks_r[rihw_pkg::TABLE_DEPTH];
  logic [CW-1:0] used_r;

  // Request registers.
  logic [2:0]    act_r;
  logic [W-1:0]  id_r, gen_r, tick_r;
  logic [CW-1:0] n_r, k_r;

  // Scan state.
  logic [CW-1:0] idx_r, kept_r;
  logic [W-1:0]  best_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic          cand_v_r, have_prev_r;
  logic [W-1:0]  cand_id_r, cand_gen_r, cand_tick_r, prev_id_r;

  // Output register.
  logic          out_valid_r, out_last_r;
  logic [135:0]  out_data_r;

  logic          is_dump;
  logic [CW-1:0] scan_lim, lim_sat, n_calc, new_used;
  logic [IW-1:0] ix;
  logic [W-1:0]  e_id, e_gen, e_tick;
  logic          id_match, eligible;
  logic [135:0]  res;

  assign is_dump  = (act_r == rihw_pkg::ACT_DUMP);
  assign scan_lim = is_dump ? n_r : used_r;
  assign ix       = idx_r[IW-1:0];
  assign e_id     = ids_r[ix];
  assign e_gen    = gens_r[ix];
  assign e_tick   = ticks_r[ix];
  assign id_match = (e_id == id_r);
  assign eligible = !have_prev_r || (e_id > prev_id_r);

  assign lim_sat = (in_limit > DEPTH_C) ? DEPTH_C : in_limit;
  assign n_calc  = (used_r < lim_sat) ? used_r : lim_sat;

  assign sts.scan_end = (idx_r == scan_lim);
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.more     = is_dump && (n_r != '0) && ((k_r + CW'(1)) != n_r);

  // Count after a remember request.
  assign new_used = (!hit_r && (used_r < DEPTH_C)) ? used_r + CW'(1) : used_r;

  // Result word for the request that is finishing.
  always_comb begin
    res = '0;
    unique case (act_r)
      rihw_pkg::ACT_LOOKUP: begin
        res[31:0]    = best_r;
        res[134:130] = used_r;
      end
      rihw_pkg::ACT_CAPACITY: begin
        res[32]      = (used_r < DEPTH_C) || hit_r;
        res[134:130] = used_r;
      end
      rihw_pkg::ACT_REMEMBER: res[134:130] = new_used;
      rihw_pkg::ACT_EXPIRE:   res[134:130] = kept_r;
      rihw_pkg::ACT_DUMP: begin
        if (n_r != '0) begin
          res[33]      = 1'b1;
          res[65:34]   = cand_id_r;
          res[97:66]   = cand_gen_r;
          res[129:98]  = cand_tick_r;
          res[134:130] = n_r;
        end
      end
      default: res[134:130] = used_r;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      act_r       <= rihw_pkg::ACT_LOOKUP;
      kept_r      <= '0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load || cmd.restart) begin
        idx_r <= '0;
      end else if (cmd.step) begin
        idx_r <= idx_r + CW'(1);
      end
      // Survivor count of an expire request.
      if (cmd.load) begin
        act_r  <= in_action;
        kept_r <= '0;
      end else if (cmd.step && (act_r == rihw_pkg::ACT_EXPIRE) && (e_tick >= tick_r)) begin
        kept_r <= kept_r + CW'(1);
      end
      if (cmd.finish) begin
        if (act_r == rihw_pkg::ACT_REMEMBER) begin
          used_r <= new_used;
        end else if (act_r == rihw_pkg::ACT_EXPIRE) begin
          used_r <= kept_r;
        end
      end
    end
  end

  // Payload registers and table writes.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r        <= in_id;
      gen_r       <= in_gen;
      tick_r      <= in_tick;
      n_r         <= n_calc;
      k_r         <= '0;
      best_r      <= '0;
      hit_r       <= 1'b0;
      hit_idx_r   <= '0;
      cand_v_r    <= 1'b0;
      have_prev_r <= 1'b0;
    end
    if (cmd.step) begin
      unique case (act_r)
        rihw_pkg::ACT_LOOKUP: begin
          if (id_match && (e_gen > best_r)) best_r <= e_gen;
        end
        rihw_pkg::ACT_CAPACITY, rihw_pkg::ACT_REMEMBER: begin
          if (id_match) begin
            hit_r     <= 1'b1;
            hit_idx_r <= ix;
          end
        end
        rihw_pkg::ACT_EXPIRE: begin
          // Compact survivors in place; the write index never passes the read index.
          if (e_tick >= tick_r) begin
            ids_r[kept_r[IW-1:0]]   <= e_id;
            gens_r[kept_r[IW-1:0]]  <= e_gen;
            ticks_r[kept_r[IW-1:0]] <= e_tick;
          end
        end
        rihw_pkg::ACT_DUMP: begin
          // Smallest id above the one emitted last.
          if (eligible && (!cand_v_r || (e_id < cand_id_r))) begin
            cand_v_r    <= 1'b1;
            cand_id_r   <= e_id;
            cand_gen_r  <= e_gen;
            cand_tick_r <= e_tick;
          end
        end
        default: ;
      endcase
    end
    if (cmd.finish) begin
      out_data_r <= res;
      out_last_r <= !sts.more;
      if (act_r == rihw_pkg::ACT_REMEMBER) begin
        if (hit_r) begin
          if (gen_r > gens_r[hit_idx_r])   gens_r[hit_idx_r]  <= gen_r;
          if (tick_r > ticks_r[hit_idx_r]) ticks_r[hit_idx_r] <= tick_r;
        end else if (used_r < DEPTH_C) begin
          ids_r[used_r[IW-1:0]]   <= id_r;
          gens_r[used_r[IW-1:0]]  <= gen_r;
          ticks_r[used_r[IW-1:0]] <= tick_r;
        end
      end
    end
    if (cmd.restart) begin
      k_r         <= k_r + CW'(1);
      prev_id_r   <= cand_id_r;
      have_prev_r <= 1'b1;
      cand_v_r    <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_C) else $error("table count above depth");
  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= idx_r || cmd.load || $past(cmd.load)) else $error("compaction overtook scan");
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r) else $error("finished request left no word");
  a_step_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> idx_r < scan_lim) else $error("scan ran past its bound");

endmodule

// ----- sv/retired_id_high_water_table_core.sv -----
// Channel | Direction | tdata / tuser / tlast
// in_     | input     | tdata: actor_id, generation, tick, dump_limit; tuser: action
// out_    | output    | tdata: result fields; tlast: last
//
// A request is loaded, then scans each stored entry in turn, then posts its word;
// a dump of n entries scans the first n slots n times.
// Reset clears the entry count and all handshake state; the table itself is not cleared.
// A stalled output holds the scan at its end until the word register frees.
module retired_id_high_water_table_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] actor_id, [63:32] generation, [95:64] tick, [100:96] dump_limit
  input  logic [103:0] in_tdata,
  // [2:0] action
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] found_generation, [32] can_remember, [33] entry_valid, [65:34] entry_id,
  // [97:66] entry_generation, [129:98] entry_tick, [134:130] table_count
  output logic [135:0] out_tdata,
  output logic         out_tlast
);

  rihw_pkg::cmd_t cmd;
  rihw_pkg::sts_t sts;

  rihw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rihw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_action  (in_tuser),
    .in_id      (in_tdata[31:0]),
    .in_gen     (in_tdata[63:32]),
    .in_tick    (in_tdata[95:64]),
    .in_limit   (in_tdata[100:96]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
